// ===== hdl/stc_pkg.sv =====
// Shared types and constants for the sprite entry to tile command block.
package stc_pkg;

  // Register indexes on the configuration port.
  localparam logic REG_BANK_OFFSET = 1'b0;
  localparam logic REG_SCREEN_FLIP = 1'b1;

  // Register reset values.
  localparam logic [2:0] BANK_OFFSET_RESET = 3'd2;
  localparam logic       SCREEN_FLIP_RESET = 1'b0;

  // Screen geometry.
  localparam logic [9:0] SCREEN_X_SHIFT = 10'h038;
  localparam logic [8:0] SCREEN_Y_TOP   = 9'd240;
  localparam logic [8:0] LARGE_Y_SHIFT  = 9'h010;

  // One classified sprite entry, as held between front and back.
  typedef struct packed {
    logic [11:0] base;
    logic [4:0]  color;
    logic        flip_x;
    logic        flip_y;
    logic        double_size;
    logic [9:0]  pos_x;
    logic [8:0]  pos_y;
  } entry_t;

endpackage

// ===== hdl/sprite_entry_to_tile_commands.sv =====
// Top level of the sprite entry to tile command block with its register port.
//
// Each input transaction carries the six attribute bytes of one sprite-list
// entry; the block answers with one 16x16 tile command for a small sprite or
// four for a large (32x32) sprite, in row-major order, with last_tile set on
// the final command of the entry. The front end decodes an entry in the cycle
// it is accepted and places it in a short queue (QUEUE_DEPTH entries); the
// back end walks the quadrants of the entry at the queue head and loads one
// command per cycle into the output register when it is not stalled. The
// output register is the one limit on rate, so sustained throughput is one
// command per clock without stalls, and input is taken every cycle while the
// queue has room, even when a finished command waits on a stalled output.
// The first command of an entry passes through the queue and then the output
// register. The bank offset register (address 0) and screen flip register
// (address 4) are written through the APB-style port and should only be
// changed while no entry is in flight.
module sprite_entry_to_tile_commands #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // Sprite entry channel.
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        tile_code,
  input  logic [7:0]        color_byte,
  input  logic [7:0]        vertical_byte,
  input  logic [7:0]        horizontal_low,
  input  logic [7:0]        attribute_byte,
  input  logic [7:0]        horizontal_high,
  // Tile command channel.
  output logic              out_valid,
  input  logic              out_stall,
  output logic [11:0]       tile_index,
  output logic [4:0]        palette_color,
  output logic              mirror_x,
  output logic              mirror_y,
  output logic signed [9:0] screen_x,
  output logic signed [8:0] screen_y,
  output logic              last_tile
);
  import stc_pkg::*;

  logic [2:0] bank_offset_reg;
  logic       screen_flip;
  logic       cfg_write;
  logic       reg_index;
  entry_t     front_entry;
  entry_t     head_entry;
  logic       queue_full;
  logic       queue_empty;
  logic       queue_pop;

  // Registers sit at byte addresses 0 and 4; bit 2 of the address picks one.
  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_offset_reg <= BANK_OFFSET_RESET;
      screen_flip     <= SCREEN_FLIP_RESET;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_BANK_OFFSET: bank_offset_reg <= pwdata[2:0];
        REG_SCREEN_FLIP: screen_flip     <= pwdata[0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_BANK_OFFSET: prdata = {29'd0, bank_offset_reg};
      REG_SCREEN_FLIP: prdata = {31'd0, screen_flip};
      default:         prdata = '0;
    endcase
  end

  // Input is held off only when the queue has no free slot.
  assign in_stall = queue_full;

  stc_front u_front (
    .tile_code       (tile_code),
    .color_byte      (color_byte),
    .vertical_byte   (vertical_byte),
    .horizontal_low  (horizontal_low),
    .attribute_byte  (attribute_byte),
    .horizontal_high (horizontal_high),
    .bank_offset     (bank_offset_reg),
    .screen_flip     (screen_flip),
    .entry           (front_entry)
  );

  stc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid),
    .push_data (front_entry),
    .full      (queue_full),
    .pop       (queue_pop),
    .head_data (head_entry),
    .empty     (queue_empty)
  );

  stc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_data     (head_entry),
    .empty         (queue_empty),
    .pop           (queue_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .tile_index    (tile_index),
    .palette_color (palette_color),
    .mirror_x      (mirror_x),
    .mirror_y      (mirror_y),
    .screen_x      (screen_x),
    .screen_y      (screen_y),
    .last_tile     (last_tile)
  );

endmodule

// ===== hdl/stc_front.sv =====
// Front end: decodes one sprite entry into bank, flips, size and position.
module stc_front (
  input  logic [7:0]          tile_code,
  input  logic [7:0]          color_byte,
  input  logic [7:0]          vertical_byte,
  input  logic [7:0]          horizontal_low,
  input  logic [7:0]          attribute_byte,
  input  logic [7:0]          horizontal_high,
  input  logic [2:0]          bank_offset,
  input  logic                screen_flip,
  output stc_pkg::entry_t     entry
);
  import stc_pkg::*;

  logic [3:0] bank;
  logic       double_size;

  always_comb begin
    double_size = attribute_byte[4];
    bank  = {3'b000, attribute_byte[0]} +
            (attribute_byte[1] ? {1'b0, bank_offset} : 4'd0);

    entry.base        = {bank, tile_code};
    entry.color       = color_byte[4:0];
    entry.flip_x      = attribute_byte[2] ^ screen_flip;
    entry.flip_y      = attribute_byte[3] ^ screen_flip;
    entry.double_size = double_size;
    entry.pos_x  = {1'b0, horizontal_high[0], horizontal_low} - SCREEN_X_SHIFT;
    entry.pos_y  = SCREEN_Y_TOP - {1'b0, vertical_byte} -
                   (double_size ? LARGE_Y_SHIFT : 9'd0);
  end

endmodule

// ===== hdl/stc_queue.sv =====
// Small register queue of classified entries between front and back.
module stc_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  stc_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output stc_pkg::entry_t head_data,
  output logic            empty
);
  import stc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  entry_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == FULL_CNT);
  assign empty     = (count == '0);
  assign head_data = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/stc_back.sv =====
// Back end: walks head-entry quadrants, one tile command per unstalled cycle.
module stc_back (
  input  logic              clk,
  input  logic              rst,
  input  stc_pkg::entry_t   head_data,
  input  logic              empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [11:0]       tile_index,
  output logic [4:0]        palette_color,
  output logic              mirror_x,
  output logic              mirror_y,
  output logic signed [9:0] screen_x,
  output logic signed [8:0] screen_y,
  output logic              last_tile
);
  import stc_pkg::*;

  logic       col;
  logic       row;
  logic       load;
  logic       is_last;
  logic       quad_x;
  logic       quad_y;
  logic [9:0] px;
  logic [8:0] py;

  // The output register takes a queued command whenever it is empty or drained.
  assign load    = !empty && (!out_valid || !out_stall);
  assign is_last = !head_data.double_size || (col && row);
  assign pop     = load && is_last;

  always_comb begin
    quad_x = head_data.double_size & (col ^ head_data.flip_x);
    quad_y = head_data.double_size & (row ^ head_data.flip_y);
    px     = head_data.pos_x + {5'b00000, col, 4'b0000};
    py     = head_data.pos_y + {4'b0000, row, 4'b0000};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      col       <= 1'b0;
      row       <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        if (is_last) begin
          col <= 1'b0;
          row <= 1'b0;
        end else begin
          col <= !col;
          row <= row | col;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tile_index    <= head_data.base + {10'd0, quad_y, quad_x};
      palette_color <= head_data.color;
      mirror_x      <= head_data.flip_x;
      mirror_y      <= head_data.flip_y;
      screen_x      <= $signed(px);
      screen_y      <= $signed(py);
      last_tile     <= is_last;
    end
  end

endmodule
